// ----- rtl/core/aeed_pkg.sv -----
// Package with the shared types, codes and constants of the envelope detector.
`default_nettype none
package aeed_pkg;
  localparam int BASELINE_SHIFT = 4;
  localparam logic [9:0] ADC_MAX = 10'd1023;
  localparam logic [31:0] HALF_RANGE = 32'h8000_0000;
  localparam logic [9:0] PER_MILLE = 10'd1000;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_INIT = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [2:0] PH_CAL = 3'd0;
  localparam logic [2:0] PH_QUIET = 3'd1;
  localparam logic [2:0] PH_EVENT = 3'd2;
  localparam logic [2:0] PH_REFR = 3'd3;
  localparam logic [2:0] PH_FAULT = 3'd4;

  localparam logic [2:0] Q_UNQ = 3'd0;
  localparam logic [2:0] Q_QUIET = 3'd1;
  localparam logic [2:0] Q_EVENT = 3'd2;
  localparam logic [2:0] Q_TIMING = 3'd3;
  localparam logic [2:0] Q_SOURCE = 3'd4;
  localparam logic [2:0] Q_CLIPLO = 3'd5;
  localparam logic [2:0] Q_CLIPHI = 3'd6;
  localparam logic [2:0] Q_DISAGREE = 3'd7;

  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_NOINIT = 4'd1;
  localparam logic [3:0] ST_INVAL = 4'd2;
  localparam logic [3:0] ST_HWFAIL = 4'd3;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_MARGIN = 3'd1;
  localparam logic [2:0] REG_ATTACK = 3'd2;
  localparam logic [2:0] REG_RELEASE = 3'd3;
  localparam logic [2:0] REG_CAL = 3'd4;
  localparam logic [2:0] REG_WINDOW = 3'd5;
  localparam logic [2:0] REG_QUIET = 3'd6;
  localparam logic [2:0] REG_REFR = 3'd7;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] sample_time;
    logic [15:0] raw_value;
    logic        comparator_present;
    logic [1:0]  comparator_level;
    logic [3:0]  analog_status;
    logic [3:0]  comparator_status;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [2:0]  phase;
    logic [2:0]  quality;
    logic [9:0]  baseline;
    logic [9:0]  amplitude;
    logic [9:0]  peak_amplitude;
    logic [9:0]  intensity;
    logic        event_started;
    logic        event_completed;
    logic        comparator_active;
    logic [31:0] event_start_time;
    logic [31:0] event_duration;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [19:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [9:0]  quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

// ----- rtl/core/aeed_stream_if.sv -----
// Valid/ready channel interfaces for input and result items.
`default_nettype none
interface aeed_in_if import aeed_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface aeed_out_if import aeed_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/aeed_divider.sv -----
// Restoring serial divider that computes the per-mille intensity quotient.
`default_nettype none
module aeed_divider import aeed_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  logic [19:0] quo_r;
  logic [15:0] rem_r;
  logic [15:0] den_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [16:0] trial;
  logic [16:0] diff;

  always_comb begin
    trial = {rem_r, quo_r[19]};
    diff = trial - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r <= 5'd20;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      den_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      if (!diff[16]) begin
        rem_r <= diff[15:0];
        quo_r <= {quo_r[18:0], 1'b1};
      end else begin
        rem_r <= trial[15:0];
        quo_r <= {quo_r[18:0], 1'b0};
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quotient = quo_r[9:0];
endmodule
`default_nettype wire

// ----- rtl/core/acoustic_event_envelope_detector_core.sv -----
// Top level of the acoustic event envelope detector.
// Each input item passes through the accept, evaluate and result states. An item
// that closes an event with a nonzero span also waits in a divide state, as the
// per-mille intensity comes from a serial divider, one quotient bit per cycle.
// The block accepts no item until the result of the previous one has been taken.
`default_nettype none
module acoustic_event_envelope_detector_core import aeed_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  aeed_in_if.sink          in_ch,
  aeed_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [30:0] cfg_wdata
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_DIV = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [1:0]  mode_r;
  logic [9:0]  margin_r, attack_r, release_r;
  logic [30:0] cal_ms_r, window_ms_r, quiet_ms_r, refr_ms_r;

  logic [1:0]  state_r;
  in_item_t    item_r;
  logic        init_r, have_r, calst_r, compv_r;
  logic [31:0] last_time_r;
  logic [26:0] last_fields_r;
  logic [2:0]  phase_r, qual_r;
  logic [3:0]  stat_r;
  logic [9:0]  base_r, amp_r, peak_r, int_r;
  logic        started_r, completed_r, cmp_r;
  logic [31:0] sstart_r, sdur_r;
  logic [31:0] t_cal_r, t_ev_r, t_qu_r, t_rf_r, t_dis_r;
  logic        cq_r, cd_r;
  logic [31:0] cstart_r, cdur_r;
  logic [9:0]  cpeak_r, cint_r;
  logic [3:0]  ret_r;

  logic [3:0]  ret_nxt;
  logic        init_nxt, have_nxt, calst_nxt, compv_nxt;
  logic [31:0] last_time_nxt;
  logic [26:0] last_fields_nxt;
  logic [2:0]  phase_nxt, qual_nxt;
  logic [3:0]  stat_nxt;
  logic [9:0]  base_nxt, amp_nxt, peak_nxt, int_nxt;
  logic        started_nxt, completed_nxt, cmp_nxt;
  logic [31:0] sstart_nxt, sdur_nxt;
  logic [31:0] t_cal_nxt, t_ev_nxt, t_qu_nxt, t_rf_nxt, t_dis_nxt;
  logic        cq_nxt, cd_nxt;
  logic [31:0] cstart_nxt, cdur_nxt;
  logic [9:0]  cpeak_nxt, cint_nxt;
  logic        div_go;
  logic [19:0] div_num;
  logic [15:0] div_den;

  div_req_t dreq;
  div_rsp_t drsp;

  aeed_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign dreq.start = (state_r == S_EVAL) && div_go;
  assign dreq.dividend = div_num;
  assign dreq.divisor = div_den;

  function automatic logic [9:0] absdiff(input logic [9:0] a, input logic [9:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic logic [9:0] track(input logic [9:0] raw, input logic [9:0] b);
    logic signed [11:0] d;
    logic signed [11:0] q;
    logic [11:0] mag;
    d = $signed({2'b00, raw}) - $signed({2'b00, b});
    mag = d[11] ? 12'(-d) : 12'(d);
    mag = mag >> BASELINE_SHIFT;
    q = d[11] ? $signed(12'(-mag)) : $signed(mag);
    return 10'($signed({2'b00, b}) + q);
  endfunction

  function automatic logic [15:0] headroom(input logic [9:0] b, input logic [9:0] m);
    logic [15:0] lo, hi;
    lo = 16'({6'd0, b} - {6'd0, m});
    hi = 16'({6'd0, ADC_MAX} - {6'd0, m} - {6'd0, b});
    return (lo > hi) ? lo : hi;
  endfunction

  function automatic logic hr_ok(input logic [9:0] b, input logic [9:0] m,
                                 input logic [9:0] a);
    logic [10:0] top;
    top = {1'b0, ADC_MAX} - {1'b0, m};
    return (b > m) && ({1'b0, b} < top) && (headroom(b, m) > {6'd0, a});
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 2'd0;
      margin_r <= 10'd1;
      attack_r <= 10'd2;
      release_r <= 10'd1;
      cal_ms_r <= 31'd1;
      window_ms_r <= 31'd1;
      quiet_ms_r <= 31'd1;
      refr_ms_r <= 31'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE: mode_r <= cfg_wdata[1:0];
        REG_MARGIN: margin_r <= cfg_wdata[9:0];
        REG_ATTACK: attack_r <= cfg_wdata[9:0];
        REG_RELEASE: release_r <= cfg_wdata[9:0];
        REG_CAL: cal_ms_r <= cfg_wdata;
        REG_WINDOW: window_ms_r <= cfg_wdata;
        REG_QUIET: quiet_ms_r <= cfg_wdata;
        REG_REFR: refr_ms_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [31:0] t, el;
    logic [9:0]  raw10, amp, b2, actl;
    logic [26:0] fields;
    logic        present, hascmp, keep, flt, fin, cfgok, pub, above;
    logic [2:0]  fq;
    logic [3:0]  fst;
    logic [15:0] span, ex;
    logic [10:0] lim;

    init_nxt = init_r; have_nxt = have_r; calst_nxt = calst_r; compv_nxt = compv_r;
    last_time_nxt = last_time_r; last_fields_nxt = last_fields_r;
    phase_nxt = phase_r; qual_nxt = qual_r; stat_nxt = stat_r; base_nxt = base_r;
    amp_nxt = amp_r; peak_nxt = peak_r; int_nxt = int_r;
    started_nxt = started_r; completed_nxt = completed_r; cmp_nxt = cmp_r;
    sstart_nxt = sstart_r; sdur_nxt = sdur_r;
    t_cal_nxt = t_cal_r; t_ev_nxt = t_ev_r; t_qu_nxt = t_qu_r;
    t_rf_nxt = t_rf_r; t_dis_nxt = t_dis_r;
    cq_nxt = cq_r; cd_nxt = cd_r;
    cstart_nxt = cstart_r; cdur_nxt = cdur_r; cpeak_nxt = cpeak_r; cint_nxt = cint_r;
    ret_nxt = stat_r;
    div_go = 1'b0; div_num = '0; div_den = '0;

    t = item_r.sample_time;
    raw10 = item_r.raw_value[9:0];
    present = item_r.comparator_present;
    fields = {item_r.comparator_status, item_r.analog_status, item_r.comparator_level,
              item_r.comparator_present, item_r.raw_value};
    hascmp = mode_r != 2'd0;
    actl = (mode_r == 2'd2) ? 10'd1 : ((mode_r == 2'd3) ? 10'd4 : 10'd0);
    el = t - last_time_r;
    keep = 1'b0; flt = 1'b0; fin = 1'b0; fq = Q_UNQ; fst = ST_OK;
    amp = '0; b2 = base_r; above = 1'b0;
    span = '0; ex = '0;
    lim = {1'b0, ADC_MAX} - {1'b0, margin_r} - {1'b0, margin_r};
    cfgok = (margin_r >= 10'd1) && (margin_r <= 10'd511) && (release_r < attack_r) &&
            (attack_r != 10'd0) && ({1'b0, attack_r} < lim) &&
            (cal_ms_r != 31'd0) && (window_ms_r != 31'd0) && (quiet_ms_r != 31'd0) &&
            (refr_ms_r != 31'd0) && (quiet_ms_r <= window_ms_r) && (mode_r <= 2'd2);
    pub = (phase_r == PH_REFR) && completed_r;

    case (item_r.opcode)
      OP_SAMPLE: begin
        if (!init_r) begin
          ret_nxt = ST_NOINIT;
        end else if (have_r && el == 32'd0 && fields == last_fields_r) begin
          ret_nxt = stat_r;
        end else if (have_r && (el == 32'd0 || el >= HALF_RANGE)) begin
          flt = 1'b1; fq = Q_TIMING; fst = ST_INVAL; keep = 1'b1;
        end else begin
          started_nxt = 1'b0; completed_nxt = 1'b0;
          if (pub) begin
            peak_nxt = '0; int_nxt = '0; sstart_nxt = '0; sdur_nxt = '0;
          end
          fin = 1'b1;
          if (phase_r == PH_FAULT) begin
            ret_nxt = stat_r;
          end else if (hascmp && present && item_r.comparator_level > 2'd1) begin
            flt = 1'b1; fq = Q_SOURCE; fst = ST_INVAL;
          end else if (item_r.analog_status != 4'd0) begin
            flt = 1'b1; fq = Q_SOURCE; fst = item_r.analog_status;
          end else if (hascmp != present) begin
            flt = 1'b1; fq = Q_SOURCE; fst = ST_HWFAIL;
          end else if (hascmp && item_r.comparator_status != 4'd0) begin
            flt = 1'b1; fq = Q_SOURCE; fst = item_r.comparator_status;
          end else if (item_r.raw_value > {6'd0, ADC_MAX}) begin
            flt = 1'b1; fq = Q_UNQ; fst = ST_INVAL;
          end else if (raw10 <= margin_r) begin
            flt = 1'b1; fq = Q_CLIPLO; fst = ST_INVAL;
          end else if ({1'b0, raw10} >= {1'b0, ADC_MAX} - {1'b0, margin_r}) begin
            flt = 1'b1; fq = Q_CLIPHI; fst = ST_INVAL;
          end else if (!calst_r) begin
            calst_nxt = 1'b1; t_cal_nxt = t; base_nxt = raw10; amp_nxt = '0;
            phase_nxt = PH_CAL; qual_nxt = Q_UNQ; stat_nxt = ST_OK; ret_nxt = ST_OK;
          end else begin
            amp = absdiff(raw10, base_r);
            amp_nxt = amp;
            above = amp >= attack_r;
            if (phase_r == PH_CAL) begin
              b2 = track(raw10, base_r);
              base_nxt = b2;
              amp_nxt = absdiff(raw10, b2);
              if (t - t_cal_r >= {1'b0, cal_ms_r}) begin
                if (!hr_ok(b2, margin_r, attack_r)) begin
                  flt = 1'b1; fq = Q_UNQ; fst = ST_INVAL;
                end else begin
                  phase_nxt = PH_QUIET; qual_nxt = Q_QUIET;
                end
              end
            end else begin
              if (!hascmp || ((mode_r == 2'd2 ? item_r.comparator_level == 2'd1 :
                  (mode_r == 2'd3 ? 1'b0 : item_r.comparator_level == 2'd0)) == above)) begin
                cd_nxt = 1'b0;
              end else if (!cd_r) begin
                cd_nxt = 1'b1; t_dis_nxt = t;
              end else if (t - t_dis_r >= {1'b0, quiet_ms_r}) begin
                flt = 1'b1; fq = Q_DISAGREE; fst = ST_HWFAIL;
              end
              if (!flt) begin
                if (phase_r == PH_EVENT) begin
                  if (amp > peak_r) peak_nxt = amp;
                  if (amp <= release_r) begin
                    if (!cq_r) begin
                      cq_nxt = 1'b1; t_qu_nxt = t;
                    end
                  end else begin
                    cq_nxt = 1'b0;
                  end
                  if ((cq_nxt && (t - t_qu_nxt >= {1'b0, quiet_ms_r})) ||
                      (t - t_ev_r >= {1'b0, window_ms_r})) begin
                    phase_nxt = PH_REFR; qual_nxt = Q_EVENT; stat_nxt = ST_OK;
                    ret_nxt = ST_OK;
                    completed_nxt = 1'b1;
                    sstart_nxt = t_ev_r; sdur_nxt = t - t_ev_r;
                    t_rf_nxt = t; cq_nxt = 1'b0;
                    cstart_nxt = t_ev_r; cdur_nxt = t - t_ev_r;
                    cpeak_nxt = peak_nxt; compv_nxt = 1'b1;
                    span = headroom(base_r, margin_r) - {6'd0, attack_r};
                    ex = (peak_nxt > attack_r) ? {6'd0, peak_nxt - attack_r} : 16'd0;
                    if (ex > span) ex = span;
                    if (span == 16'd0) begin
                      int_nxt = '0; cint_nxt = '0;
                    end else begin
                      div_go = 1'b1;
                      div_num = 20'(ex[9:0] * PER_MILLE);
                      div_den = span;
                    end
                  end
                end else if (phase_r == PH_REFR &&
                             (t - t_rf_r < {1'b0, refr_ms_r})) begin
                  qual_nxt = Q_QUIET; stat_nxt = ST_OK; ret_nxt = ST_OK;
                end else if (above) begin
                  phase_nxt = PH_EVENT; qual_nxt = Q_EVENT; stat_nxt = ST_OK;
                  ret_nxt = ST_OK;
                  peak_nxt = amp; int_nxt = '0; started_nxt = 1'b1;
                  sstart_nxt = t; sdur_nxt = '0; t_ev_nxt = t; cq_nxt = 1'b0;
                end else begin
                  b2 = track(raw10, base_r);
                  base_nxt = b2;
                  if (!hr_ok(b2, margin_r, attack_r)) begin
                    flt = 1'b1; fq = Q_UNQ; fst = ST_INVAL;
                  end else begin
                    phase_nxt = PH_QUIET; qual_nxt = Q_QUIET; stat_nxt = ST_OK;
                    ret_nxt = ST_OK;
                  end
                end
              end
            end
          end
        end
        if (flt) begin
          if (!(fq == Q_SOURCE && fst == ST_INVAL && hascmp && present &&
                item_r.comparator_level > 2'd1))
            cmp_nxt = hascmp && present && ({8'd0, item_r.comparator_level} == actl);
          started_nxt = 1'b0; completed_nxt = 1'b0;
          phase_nxt = PH_FAULT; qual_nxt = fq; stat_nxt = fst; ret_nxt = fst;
          if (!keep || !compv_r) begin
            if (!keep) amp_nxt = '0;
            peak_nxt = '0; int_nxt = '0; sstart_nxt = '0; sdur_nxt = '0;
          end else begin
            peak_nxt = cpeak_r; int_nxt = cint_r; sstart_nxt = cstart_r; sdur_nxt = cdur_r;
          end
          fin = 1'b1;
        end else if (fin && phase_r != PH_FAULT && init_r &&
                     item_r.raw_value <= {6'd0, ADC_MAX} &&
                     !(item_r.analog_status != 4'd0)) begin
          cmp_nxt = hascmp && ({8'd0, item_r.comparator_level} == actl);
        end
        if (fin) begin
          last_time_nxt = t; last_fields_nxt = fields; have_nxt = 1'b1;
        end
      end
      OP_INIT: begin
        if (init_r) begin
          ret_nxt = ST_OK;
        end else if (!cfgok) begin
          ret_nxt = ST_INVAL;
        end else begin
          init_nxt = 1'b1;
        end
      end
      default: ret_nxt = stat_r;
    endcase

    if ((item_r.opcode == OP_INIT && !init_r && cfgok) || item_r.opcode == OP_RESTART) begin
      phase_nxt = PH_CAL; qual_nxt = Q_UNQ; base_nxt = '0; amp_nxt = '0;
      peak_nxt = '0; int_nxt = '0; sstart_nxt = '0; sdur_nxt = '0;
      started_nxt = 1'b0; completed_nxt = 1'b0; cmp_nxt = 1'b0;
      have_nxt = 1'b0; calst_nxt = 1'b0; cq_nxt = 1'b0; cd_nxt = 1'b0;
      last_time_nxt = '0; last_fields_nxt = '0;
      t_cal_nxt = '0; t_ev_nxt = '0; t_qu_nxt = '0; t_rf_nxt = '0; t_dis_nxt = '0;
      compv_nxt = 1'b0; cstart_nxt = '0; cdur_nxt = '0; cpeak_nxt = '0; cint_nxt = '0;
      stat_nxt = init_nxt ? ST_OK : ST_NOINIT;
      ret_nxt = stat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      init_r <= 1'b0; have_r <= 1'b0; calst_r <= 1'b0; compv_r <= 1'b0;
      last_time_r <= '0; last_fields_r <= '0;
      phase_r <= PH_CAL; qual_r <= Q_UNQ; stat_r <= ST_NOINIT; base_r <= '0;
      amp_r <= '0; peak_r <= '0; int_r <= '0;
      started_r <= 1'b0; completed_r <= 1'b0; cmp_r <= 1'b0;
      sstart_r <= '0; sdur_r <= '0;
      t_cal_r <= '0; t_ev_r <= '0; t_qu_r <= '0; t_rf_r <= '0; t_dis_r <= '0;
      cq_r <= 1'b0; cd_r <= 1'b0;
      cstart_r <= '0; cdur_r <= '0; cpeak_r <= '0; cint_r <= '0;
      ret_r <= ST_NOINIT;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            item_r <= in_ch.data;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          init_r <= init_nxt; have_r <= have_nxt; calst_r <= calst_nxt;
          compv_r <= compv_nxt;
          last_time_r <= last_time_nxt; last_fields_r <= last_fields_nxt;
          phase_r <= phase_nxt; qual_r <= qual_nxt; stat_r <= stat_nxt;
          base_r <= base_nxt;
          amp_r <= amp_nxt; peak_r <= peak_nxt; int_r <= int_nxt;
          started_r <= started_nxt; completed_r <= completed_nxt; cmp_r <= cmp_nxt;
          sstart_r <= sstart_nxt; sdur_r <= sdur_nxt;
          t_cal_r <= t_cal_nxt; t_ev_r <= t_ev_nxt; t_qu_r <= t_qu_nxt;
          t_rf_r <= t_rf_nxt; t_dis_r <= t_dis_nxt;
          cq_r <= cq_nxt; cd_r <= cd_nxt;
          cstart_r <= cstart_nxt; cdur_r <= cdur_nxt; cpeak_r <= cpeak_nxt;
          cint_r <= cint_nxt;
          ret_r <= ret_nxt;
          state_r <= div_go ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (drsp.done) begin
            int_r <= drsp.quotient;
            cint_r <= drsp.quotient;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data.status = ret_r;
  assign out_ch.data.phase = phase_r;
  assign out_ch.data.quality = qual_r;
  assign out_ch.data.baseline = base_r;
  assign out_ch.data.amplitude = amp_r;
  assign out_ch.data.peak_amplitude = peak_r;
  assign out_ch.data.intensity = int_r;
  assign out_ch.data.event_started = started_r;
  assign out_ch.data.event_completed = completed_r;
  assign out_ch.data.comparator_active = cmp_r;
  assign out_ch.data.event_start_time = sstart_r;
  assign out_ch.data.event_duration = sdur_r;
endmodule
`default_nettype wire

// ----- verif/tb_acoustic_event_envelope_detector_core.sv -----
// Self-checking testbench for the acoustic event envelope detector core.
module tb_acoustic_event_envelope_detector_core import aeed_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [30:0] cfg_wdata = '0;

  aeed_in_if in_ch ();
  aeed_out_if out_ch ();

  acoustic_event_envelope_detector_core i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // Predictor state.
  logic [1:0] m_mode;
  logic [9:0] m_margin, m_attack, m_release;
  logic [30:0] m_cal, m_window, m_quiet, m_refr;
  bit m_init, m_have, m_cal_started;
  logic [31:0] m_last_time;
  logic [26:0] m_last_fields;
  logic [2:0] m_phase, m_quality;
  logic [3:0] m_status;
  logic [9:0] m_base, s_amp, s_peak, s_int;
  logic [31:0] s_start, s_dur;
  bit s_started, s_completed, s_cmp;
  logic [31:0] t_cal, t_event, t_quiet, t_refr, t_dis;
  bit cand_quiet, cand_dis;
  bit c_valid;
  logic [31:0] c_start, c_dur;
  logic [9:0] c_peak, c_int;

  out_item_t expected_results[$];
  int errors = 0;
  int idle_cycles = 0;
  bit out_hold = 1'b0;
  logic [31:0] now_ms;

  function automatic void clear_event();
    s_peak = '0; s_int = '0; s_start = '0; s_dur = '0;
  endfunction

  function automatic void restart_state();
    m_phase = PH_CAL; m_quality = Q_UNQ; m_status = ST_NOINIT;
    m_base = '0; s_amp = '0; clear_event();
    s_started = 0; s_completed = 0; s_cmp = 0;
    m_have = 0; m_cal_started = 0; cand_quiet = 0; cand_dis = 0;
    m_last_time = '0; m_last_fields = '0;
    t_cal = '0; t_event = '0; t_quiet = '0; t_refr = '0; t_dis = '0;
    c_valid = 0; c_start = '0; c_dur = '0; c_peak = '0; c_int = '0;
    if (m_init) m_status = ST_OK;
  endfunction

  function automatic logic [1:0] active_lvl();
    return (m_mode == 2'd2) ? 2'd1 : ((m_mode == 2'd3) ? 2'd3 : 2'd0);
  endfunction

  function automatic bit cfg_good();
    return m_margin >= 1 && m_margin <= 511 && m_release < m_attack && m_attack != 0 &&
           32'(m_attack) < 32'(ADC_MAX) - 2 * 32'(m_margin) &&
           m_cal != 0 && m_window != 0 && m_quiet != 0 && m_refr != 0 &&
           m_quiet <= m_window && m_mode <= 2;
  endfunction

  function automatic void remember(logic [31:0] t, logic [26:0] f);
    m_last_time = t; m_last_fields = f; m_have = 1;
  endfunction

  function automatic logic [3:0] go_fault(logic [31:0] t, logic [26:0] f, bit pres,
                                          logic [1:0] lvl, logic [2:0] q,
                                          logic [3:0] st, bit keep);
    s_cmp = (m_mode != 0) && pres && (m_mode != 2'd3) && lvl == active_lvl();
    s_started = 0; s_completed = 0;
    m_phase = PH_FAULT; m_quality = q; m_status = st;
    if (!keep) begin
      s_amp = '0; clear_event();
    end else if (c_valid) begin
      s_peak = c_peak; s_int = c_int; s_start = c_start; s_dur = c_dur;
    end else begin
      clear_event();
    end
    remember(t, f);
    return m_status;
  endfunction

  function automatic logic [9:0] amp_of(logic [15:0] raw);
    return (32'(raw) >= 32'(m_base)) ? 10'(raw - m_base) : 10'(m_base - raw);
  endfunction

  function automatic void track(logic [15:0] raw);
    int diff;
    diff = int'(raw) - int'(m_base);
    m_base = 10'(int'(m_base) + diff / (1 << BASELINE_SHIFT));
  endfunction

  function automatic logic [15:0] headroom();
    logic [15:0] lo, hi;
    lo = 16'(32'(m_base) - 32'(m_margin));
    hi = 16'(32'(ADC_MAX) - 32'(m_margin) - 32'(m_base));
    return (lo > hi) ? lo : hi;
  endfunction

  function automatic bit headroom_ok();
    return m_base > m_margin && 32'(m_base) < 32'(ADC_MAX) - 32'(m_margin) &&
           headroom() > 16'(m_attack);
  endfunction

  function automatic logic [9:0] intensity_now();
    logic [15:0] span;
    logic [31:0] ex;
    span = headroom() - 16'(m_attack);
    ex = (s_peak > m_attack) ? 32'(s_peak - m_attack) : 0;
    if (ex > 32'(span)) ex = 32'(span);
    if (span == 0) return '0;
    return 10'((ex * 1000) / 32'(span));
  endfunction

  function automatic void close_event(logic [31:0] t);
    m_phase = PH_REFR; m_quality = Q_EVENT; m_status = ST_OK;
    s_completed = 1; s_start = t_event; s_dur = t - t_event;
    s_int = intensity_now(); t_refr = t; cand_quiet = 0;
    c_start = s_start; c_dur = s_dur; c_peak = s_peak; c_int = s_int; c_valid = 1;
  endfunction

  function automatic logic [3:0] sample_op(in_item_t it);
    logic [31:0] t, el;
    logic [15:0] raw;
    logic [26:0] f;
    logic [9:0] amp;
    bit pres, pub, has_cmp, prev, above;
    logic [1:0] lvl;
    logic [3:0] st;
    t = it.sample_time; raw = it.raw_value; pres = it.comparator_present;
    lvl = it.comparator_level;
    f = {it.comparator_status, it.analog_status, lvl, pres, raw};
    has_cmp = m_mode != 0;
    if (!m_init) return ST_NOINIT;
    if (m_have) begin
      el = t - m_last_time;
      if (el == 0) begin
        if (f == m_last_fields) return m_status;
        return go_fault(t, f, pres, lvl, Q_TIMING, ST_INVAL, 1);
      end
      if (el >= HALF_RANGE) return go_fault(t, f, pres, lvl, Q_TIMING, ST_INVAL, 1);
    end
    pub = m_phase == PH_REFR && s_completed;
    s_started = 0; s_completed = 0;
    if (pub) clear_event();
    if (m_phase == PH_FAULT) begin
      remember(t, f);
      return m_status;
    end
    if (has_cmp && pres && lvl > 1) begin
      prev = s_cmp;
      st = go_fault(t, f, pres, lvl, Q_SOURCE, ST_INVAL, 0);
      s_cmp = prev;
      return st;
    end
    if (it.analog_status != 0) return go_fault(t, f, pres, lvl, Q_SOURCE, it.analog_status, 0);
    if (has_cmp != pres) return go_fault(t, f, pres, lvl, Q_SOURCE, ST_HWFAIL, 0);
    if (has_cmp && it.comparator_status != 0)
      return go_fault(t, f, pres, lvl, Q_SOURCE, it.comparator_status, 0);
    if (raw > 16'(ADC_MAX)) return go_fault(t, f, pres, lvl, Q_UNQ, ST_INVAL, 0);
    s_cmp = has_cmp && m_mode != 2'd3 && lvl == active_lvl();
    if (raw <= 16'(m_margin)) return go_fault(t, f, pres, lvl, Q_CLIPLO, ST_INVAL, 0);
    if (32'(raw) >= 32'(ADC_MAX) - 32'(m_margin))
      return go_fault(t, f, pres, lvl, Q_CLIPHI, ST_INVAL, 0);
    if (!m_cal_started) begin
      m_cal_started = 1; t_cal = t; m_base = 10'(raw); s_amp = '0;
      m_phase = PH_CAL; m_quality = Q_UNQ; m_status = ST_OK;
      remember(t, f);
      return m_status;
    end
    amp = amp_of(raw);
    s_amp = amp;
    if (m_phase == PH_CAL) begin
      track(raw);
      s_amp = amp_of(raw);
      if (t - t_cal >= 32'(m_cal)) begin
        if (!headroom_ok()) return go_fault(t, f, pres, lvl, Q_UNQ, ST_INVAL, 0);
        m_phase = PH_QUIET; m_quality = Q_QUIET;
      end
      remember(t, f);
      return m_status;
    end
    above = amp >= m_attack;
    if (!has_cmp || s_cmp == above) begin
      cand_dis = 0;
    end else if (!cand_dis) begin
      cand_dis = 1; t_dis = t;
    end else if (t - t_dis >= 32'(m_quiet)) begin
      return go_fault(t, f, pres, lvl, Q_DISAGREE, ST_HWFAIL, 0);
    end
    if (m_phase == PH_EVENT) begin
      if (amp > s_peak) s_peak = amp;
      if (amp <= m_release) begin
        if (!cand_quiet) begin
          cand_quiet = 1; t_quiet = t;
        end
      end else begin
        cand_quiet = 0;
      end
      if ((cand_quiet && t - t_quiet >= 32'(m_quiet)) || t - t_event >= 32'(m_window))
        close_event(t);
      remember(t, f);
      return m_status;
    end
    if (m_phase == PH_REFR) begin
      if (t - t_refr < 32'(m_refr)) begin
        m_quality = Q_QUIET; m_status = ST_OK;
        remember(t, f);
        return m_status;
      end
      m_phase = PH_QUIET; m_quality = Q_QUIET;
    end
    if (above) begin
      m_phase = PH_EVENT; m_quality = Q_EVENT; m_status = ST_OK;
      s_peak = amp; s_int = '0; s_started = 1; s_completed = 0;
      s_start = t; s_dur = '0; t_event = t; cand_quiet = 0;
    end else begin
      track(raw);
      if (!headroom_ok()) return go_fault(t, f, pres, lvl, Q_UNQ, ST_INVAL, 0);
      m_phase = PH_QUIET; m_quality = Q_QUIET; m_status = ST_OK;
    end
    remember(t, f);
    return m_status;
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    logic [3:0] st;
    case (it.opcode)
      OP_SAMPLE: st = sample_op(it);
      OP_INIT: begin
        if (m_init) st = ST_OK;
        else if (!cfg_good()) st = ST_INVAL;
        else begin
          m_init = 1; restart_state(); st = ST_OK;
        end
      end
      OP_RESTART: begin
        restart_state(); st = m_status;
      end
      default: st = m_status;
    endcase
    r.status = st; r.phase = m_phase; r.quality = m_quality; r.baseline = m_base;
    r.amplitude = s_amp; r.peak_amplitude = s_peak; r.intensity = s_int;
    r.event_started = s_started; r.event_completed = s_completed;
    r.comparator_active = s_cmp; r.event_start_time = s_start; r.event_duration = s_dur;
    return r;
  endfunction

  function automatic void set_model_reg(logic [2:0] idx, logic [30:0] v);
    case (idx)
      REG_MODE: m_mode = v[1:0];
      REG_MARGIN: m_margin = v[9:0];
      REG_ATTACK: m_attack = v[9:0];
      REG_RELEASE: m_release = v[9:0];
      REG_CAL: m_cal = v;
      REG_WINDOW: m_window = v;
      REG_QUIET: m_quiet = v;
      default: m_refr = v;
    endcase
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [30:0] v);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    set_model_reg(idx, v);
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  // Valid and data are driven with blocking assignments so that an item that
  // follows with no gap can raise valid again in the same falling-edge step.
  task automatic send_item(in_item_t it, bit use_gap);
    int g;
    g = use_gap ? gap_len() : 0;
    repeat (g) @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.data = it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_results.push_back(predict_result(it));
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  function automatic in_item_t make_sample(logic [15:0] raw);
    in_item_t it;
    it.opcode = OP_SAMPLE; it.sample_time = now_ms; it.raw_value = raw;
    it.comparator_present = m_mode != 0;
    it.comparator_level = (32'(raw) > 32'(m_base) + 32'(m_attack) ||
                           32'(raw) + 32'(m_attack) < 32'(m_base)) ?
                          active_lvl() : ~active_lvl() & 2'd1;
    it.analog_status = '0; it.comparator_status = '0;
    return it;
  endfunction

  task automatic send_op(logic [1:0] op);
    in_item_t it;
    it = make_sample(16'd500);
    it.opcode = op;
    send_item(it, 1);
  endtask

  task automatic program_config(logic [1:0] mode, logic [9:0] margin, logic [9:0] atk,
                                logic [9:0] rel, logic [30:0] cal, logic [30:0] win,
                                logic [30:0] qt, logic [30:0] rf);
    write_reg(REG_MODE, 31'(mode)); write_reg(REG_MARGIN, 31'(margin));
    write_reg(REG_ATTACK, 31'(atk)); write_reg(REG_RELEASE, 31'(rel));
    write_reg(REG_CAL, cal); write_reg(REG_WINDOW, win);
    write_reg(REG_QUIET, qt); write_reg(REG_REFR, rf);
  endtask

  task automatic test_directed();
    in_item_t it;
    now_ms = 32'd100;
    send_op(OP_SAMPLE);
    send_op(OP_INIT);
    send_op(2'd3);
    send_op(OP_RESTART);
    wait_drained();
    program_config(2'd2, 10'd20, 10'd40, 10'd10, 31'd3, 31'd20, 31'd4, 31'd5);
    send_op(OP_INIT);
    send_op(OP_INIT);
    for (int i = 0; i < 6; i++) begin
      now_ms += 1; send_item(make_sample(16'd500), 1);
    end
    now_ms += 1; send_item(make_sample(16'd900), 1);
    now_ms += 1; send_item(make_sample(16'd1000), 1);
    now_ms += 1; send_item(make_sample(16'd1000), 1);
    send_item(make_sample(16'd1000), 1);
    for (int i = 0; i < 6; i++) begin
      now_ms += 1; send_item(make_sample(16'd500), 1);
    end
    it = make_sample(16'd500); it.raw_value = 16'hFFFF; now_ms += 1; it.sample_time = now_ms;
    send_item(it, 1);
    it.sample_time = now_ms; it.raw_value = 16'd501; send_item(it, 1);
    send_op(OP_RESTART);
    now_ms += 32'h8000_0000; send_item(make_sample(16'd0), 1);
    now_ms += 1; it = make_sample(16'd500); it.comparator_level = 2'd3; send_item(it, 1);
    send_op(OP_RESTART);
    wait_drained();
  endtask

  task automatic test_config_edges();
    program_config(2'd3, 10'd1023, 10'd1023, 10'd1023, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                   31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_op(OP_RESTART);
    send_op(OP_SAMPLE);
    wait_drained();
    program_config(2'd0, 10'd0, 10'd0, 10'd0, 31'd0, 31'd0, 31'd0, 31'd0);
    send_op(OP_SAMPLE);
    wait_drained();
  endtask

  // Mostly well-formed envelope traffic, with some broken fields, repeated timestamps and restarts.
  task automatic run_random(int count, bit use_gap);
    in_item_t it;
    int r;
    logic [63:0] rnd;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      now_ms += $urandom_range(1, 3);
      if (r < 3) begin
        send_op(OP_RESTART);
      end else if (r < 5) begin
        rnd = {$urandom, $urandom};
        it = rnd[$bits(in_item_t)-1:0];
        send_item(it, use_gap);
      end else if (r < 8) begin
        it = make_sample(16'($urandom_range(0, 1023)));
        it.sample_time = m_last_time;
        if ($urandom_range(0, 1)) it = make_sample(m_last_fields[15:0]);
        if ($urandom_range(0, 1)) it.sample_time = m_last_time;
        send_item(it, use_gap);
      end else begin
        if ($urandom_range(0, 3) == 0)
          it = make_sample(16'($urandom_range(480, 1000)));
        else
          it = make_sample(16'($urandom_range(470, 530)));
        if ($urandom_range(0, 40) == 0) it.analog_status = 4'($urandom);
        if ($urandom_range(0, 40) == 0) it.comparator_status = 4'($urandom);
        if ($urandom_range(0, 40) == 0) it.comparator_present = ~it.comparator_present;
        if ($urandom_range(0, 40) == 0) it.comparator_level = 2'($urandom);
        send_item(it, use_gap);
      end
    end
  endtask

  task automatic test_random();
    for (int k = 0; k < 4; k++) begin
      program_config(2'(k % 3), 10'($urandom_range(1, 60)), 10'($urandom_range(20, 120)),
                     10'($urandom_range(0, 15)), 31'($urandom_range(1, 8)),
                     31'($urandom_range(12, 40)), 31'($urandom_range(1, 10)),
                     31'($urandom_range(1, 8)));
      send_op(OP_RESTART);
      send_op(OP_INIT);
      send_op(OP_RESTART);
      run_random(250, 1);
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    send_op(OP_RESTART);
    out_hold = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk);
        out_hold = 1'b0;
      end
      run_random(40, 0);
    join
    wait_drained();
  endtask

  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, out_ch.data);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_ch.data !== exp_r) begin
          $display("%0t: mismatch expected %h actual %h", $realtime, exp_r, out_ch.data);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= !out_hold && ($urandom_range(0, 9) < 7 || $urandom_range(0, 30) == 0);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    m_mode = 2'd0; m_margin = 10'd1; m_attack = 10'd2; m_release = 10'd1;
    m_cal = 31'd1; m_window = 31'd1; m_quiet = 31'd1; m_refr = 31'd1;
    m_init = 0;
    restart_state();
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_config_edges();
    test_random();
    test_backpressure();
    wait_drained();
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ----- acoustic_event_envelope_detector_core.f -----
rtl/core/aeed_pkg.sv
rtl/core/aeed_stream_if.sv
rtl/core/aeed_divider.sv
rtl/core/acoustic_event_envelope_detector_core.sv
verif/tb_acoustic_event_envelope_detector_core.sv
